// ----- rtl/hvd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, the CORDIC arctangent table and common types for the
// haversine distance pipeline.
// ----------------------------------------------------------------------------
package hvd_pkg;

  typedef logic signed [31:0] q30_t;

  localparam int CORDIC_ITERS = 31;
  localparam int GAIN_Q30     = 652032875;
  localparam int ONE_Q30      = 1 << 30;
  localparam int PI_Q29       = 1686629713;
  localparam int DIST_MAX     = 52706100;
  localparam int RADIUS_RESET = 6371;

  // phase divider: numerator width, padded width, bits per stage
  localparam int PHASE_NUM_W = 38;
  localparam int DIV_PAD_W   = 40;
  localparam int DIV_STEP    = 4;
  localparam int DIV_REM_W   = 6;
  localparam int DIV_BASE    = 45;

  // square root: radicand and root widths
  localparam int SQ_IN_W = 61;
  localparam int ROOT_W  = 31;

  // arctangent of 2^-i as a fraction of a 2^32 turn
  localparam logic [29:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
  };

endpackage

// ----- rtl/haversine_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points by the haversine formula, fully
// pipelined: phase dividers, sine/cosine CORDICs, products, square roots,
// atan2 CORDIC and radius scale.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+----------------------
//   command  | start, busy, first/second lat/lon         | start && !busy
//   result   | done, distance_km                         | done, one cycle
//   config   | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
//
// One transaction enters per clock; busy is always low since nothing
// downstream can push back. A result passes from its command through the
// phase divider, sine/cosine CORDIC, products, square root, atan2 CORDIC
// and scaling, in that order. rst is synchronous and clears all valid bits;
// data registers are not reset. The radius register resets to 6371 km; the
// user must write it only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module haversine_distance import hvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] first_latitude,
  input  logic signed [24:0] first_longitude,
  input  logic signed [23:0] second_latitude,
  input  logic signed [24:0] second_longitude,
  output logic               done,
  output logic [25:0]        distance_km,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  // --- configuration --------------------------------------------------------
  logic [15:0] radius_km;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_km <= 16'(RADIUS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      radius_km <= cfg_data;
    end
  end

  // No back-pressure anywhere in the pipe.
  assign busy = 1'b0;

  // --- input stage: numerators for the phase dividers ----------------------
  // Half-angle phase: floor((d*2^16 + 360) / 720) = floor((d*2^12 + 22) / 45)
  // Full-angle phase: floor((d*2^16 + 180) / 360) = floor((d*2^13 + 22) / 45)
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  logic signed [PHASE_NUM_W-1:0] num_dlat, num_dlon, num_lat1, num_lat2;
  logic v_in;

  assign dlat = 25'(second_latitude) - 25'(first_latitude);
  assign dlon = 26'(second_longitude) - 26'(first_longitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in <= 1'b0;
    end else begin
      v_in <= start && !busy;
    end
    num_dlat <= (PHASE_NUM_W'(dlat) <<< 12) + PHASE_NUM_W'(22);
    num_dlon <= (PHASE_NUM_W'(dlon) <<< 12) + PHASE_NUM_W'(22);
    num_lat1 <= (PHASE_NUM_W'(first_latitude) <<< 13) + PHASE_NUM_W'(22);
    num_lat2 <= (PHASE_NUM_W'(second_latitude) <<< 13) + PHASE_NUM_W'(22);
  end

  // --- phases ---------------------------------------------------------------
  logic [31:0] ph_dlat, ph_dlon, ph_lat1, ph_lat2;
  logic        pv_dlat, pv_dlon, pv_lat1, pv_lat2;

  hvd_phase u_ph_dlat (.clk, .rst, .in_valid(v_in), .num(num_dlat),
                       .out_valid(pv_dlat), .phase(ph_dlat));
  hvd_phase u_ph_dlon (.clk, .rst, .in_valid(v_in), .num(num_dlon),
                       .out_valid(pv_dlon), .phase(ph_dlon));
  hvd_phase u_ph_lat1 (.clk, .rst, .in_valid(v_in), .num(num_lat1),
                       .out_valid(pv_lat1), .phase(ph_lat1));
  hvd_phase u_ph_lat2 (.clk, .rst, .in_valid(v_in), .num(num_lat2),
                       .out_valid(pv_lat2), .phase(ph_lat2));

  logic v_ph;
  assign v_ph = pv_dlat & pv_dlon & pv_lat1 & pv_lat2;

  // --- sines and cosines ----------------------------------------------------
  q30_t s_lat, s_lon, c_lat1, c_lat2;
  logic rv_slat, rv_slon, rv_c1, rv_c2;

  hvd_rotator u_rot_slat (.clk, .rst, .in_valid(v_ph), .phase(ph_dlat), .want_cos(1'b0),
                          .out_valid(rv_slat), .result(s_lat));
  hvd_rotator u_rot_slon (.clk, .rst, .in_valid(v_ph), .phase(ph_dlon), .want_cos(1'b0),
                          .out_valid(rv_slon), .result(s_lon));
  hvd_rotator u_rot_c1   (.clk, .rst, .in_valid(v_ph), .phase(ph_lat1), .want_cos(1'b1),
                          .out_valid(rv_c1), .result(c_lat1));
  hvd_rotator u_rot_c2   (.clk, .rst, .in_valid(v_ph), .phase(ph_lat2), .want_cos(1'b1),
                          .out_valid(rv_c2), .result(c_lat2));

  logic v_rot;
  assign v_rot = rv_slat & rv_slon & rv_c1 & rv_c2;

  // --- a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2), clamped to [0, 1] -----
  logic signed [63:0] p_lat, p_cos, p_lon, p_t2;
  q30_t               t1_b, t1_c, cc_b, sl_b;
  logic [ROOT_W-1:0]  a_q, b_q;
  logic signed [34:0] a_sum;
  logic               v_a, v_b, v_c, v_d;

  assign a_sum = 35'(t1_c) + 35'(p_t2 >>> 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_a <= v_rot;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
    p_lat <= s_lat * s_lat;
    p_cos <= c_lat1 * c_lat2;
    p_lon <= s_lon * s_lon;
    t1_b  <= 32'(p_lat >>> 30);
    cc_b  <= 32'(p_cos >>> 30);
    sl_b  <= 32'(p_lon >>> 30);
    t1_c  <= t1_b;
    p_t2  <= cc_b * sl_b;
    if (a_sum < 0) begin
      a_q <= '0;
      b_q <= ROOT_W'(ONE_Q30);
    end else if (a_sum > 35'(ONE_Q30)) begin
      a_q <= ROOT_W'(ONE_Q30);
      b_q <= '0;
    end else begin
      a_q <= a_sum[ROOT_W-1:0];
      b_q <= ROOT_W'(ONE_Q30) - a_sum[ROOT_W-1:0];
    end
  end

  // --- square roots of a and 1 - a -----------------------------------------
  logic [ROOT_W-1:0] root_a, root_b;
  logic              sv_a, sv_b;

  hvd_isqrt u_sqrt_a (.clk, .rst, .in_valid(v_d), .radicand({a_q, 30'd0}),
                      .out_valid(sv_a), .root(root_a));
  hvd_isqrt u_sqrt_b (.clk, .rst, .in_valid(v_d), .radicand({b_q, 30'd0}),
                      .out_valid(sv_b), .root(root_b));

  // --- central angle --------------------------------------------------------
  logic [ROOT_W-1:0] z_turn;
  logic              v_z;

  hvd_atan2 u_atan2 (.clk, .rst, .in_valid(sv_a & sv_b), .yv(root_a), .xv(root_b),
                     .out_valid(v_z), .angle(z_turn));

  // --- c = 2*atan2 in radians Q30, then distance = R*c in km Q8 ------------
  logic [61:0] p_pi;
  logic [32:0] c_rad;
  logic [48:0] p_dist;
  logic [26:0] d_round;
  logic        v_p, v_c2, v_r;

  assign d_round = 27'((p_dist + 49'(1 << 21)) >> 22);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p  <= 1'b0;
      v_c2 <= 1'b0;
      v_r  <= 1'b0;
      done <= 1'b0;
    end else begin
      v_p  <= v_z;
      v_c2 <= v_p;
      v_r  <= v_c2;
      done <= v_r;
    end
    p_pi        <= 62'(z_turn) * 62'(PI_Q29);
    c_rad       <= 33'((p_pi + 62'(1 << 28)) >> 29);
    p_dist      <= 49'(radius_km) * 49'(c_rad);
    distance_km <= (d_round > 27'(DIST_MAX)) ? 26'(DIST_MAX) : d_round[25:0];
  end

  // --- checks ---------------------------------------------------------------
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    done |-> distance_km <= 26'(DIST_MAX))
    else $error("distance above saturation limit");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_zero_radius: assert property (@(posedge clk) disable iff (rst)
    done && ($past(radius_km, 2) == 16'd0) |-> distance_km == 26'd0)
    else $error("nonzero distance with zero radius");

endmodule

// ----- rtl/hvd_phase.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_phase
// Pipelined floor division of a signed numerator by 45, giving a 32 bit
// turn phase. Four quotient bits per stage.
// ----------------------------------------------------------------------------
module hvd_phase import hvd_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic signed [PHASE_NUM_W-1:0] num,
  output logic                          out_valid,
  output logic [31:0]                   phase
);

  localparam int STAGES = DIV_PAD_W / DIV_STEP;

  function automatic logic [DIV_STEP+DIV_REM_W-1:0] div_step(
    input logic [DIV_REM_W-1:0] rem,
    input logic [DIV_STEP-1:0]  bits
  );
    logic [DIV_REM_W:0]    r;
    logic [DIV_STEP-1:0]   q;
    r = {1'b0, rem};
    q = '0;
    for (int k = DIV_STEP - 1; k >= 0; k--) begin
      r = {r[DIV_REM_W-1:0], bits[k]};
      if (r >= (DIV_REM_W+1)'(DIV_BASE)) begin
        r    = r - (DIV_REM_W+1)'(DIV_BASE);
        q[k] = 1'b1;
      end
    end
    return {q, r[DIV_REM_W-1:0]};
  endfunction

  logic signed [DIV_PAD_W-1:0] num_ext;
  logic                        neg_q   [0:STAGES];
  logic [DIV_PAD_W-1:0]        quo_q   [0:STAGES];
  logic [DIV_PAD_W-1:0]        num_q   [0:STAGES-1];
  logic [DIV_REM_W-1:0]        rem_q   [0:STAGES-1];
  logic                        valid_q [0:STAGES];

  assign num_ext = DIV_PAD_W'(num);

  // floor for negatives: -floor((-m + 44) / 45)
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid;
    end
    neg_q[0] <= num_ext[DIV_PAD_W-1];
    num_q[0] <= num_ext[DIV_PAD_W-1] ? DIV_PAD_W'(DIV_BASE - 1) - num_ext : num_ext;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
  end

  for (genvar s = 1; s <= STAGES; s++) begin : g_stage
    logic [DIV_STEP+DIV_REM_W-1:0] step;
    assign step = div_step(rem_q[s-1], num_q[s-1][DIV_PAD_W-1 -: DIV_STEP]);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_q[s-1];
      end
      neg_q[s] <= neg_q[s-1];
      quo_q[s] <= {quo_q[s-1][DIV_PAD_W-DIV_STEP-1:0], step[DIV_STEP+DIV_REM_W-1 -: DIV_STEP]};
    end

    if (s < STAGES) begin : g_more
      always_ff @(posedge clk) begin
        num_q[s] <= num_q[s-1] << DIV_STEP;
        rem_q[s] <= step[DIV_REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_q[STAGES];
    end
    phase <= neg_q[STAGES] ? 32'd0 - quo_q[STAGES][31:0] : quo_q[STAGES][31:0];
  end

endmodule

// ----- rtl/hvd_rotator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_rotator
// Rotation-mode CORDIC, one iteration per stage; gives sine or cosine of a
// 32 bit turn phase in Q30.
// ----------------------------------------------------------------------------
module hvd_rotator import hvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] phase,
  input  logic        want_cos,
  output logic        out_valid,
  output q30_t        result
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_q     [0:CORDIC_ITERS];
  logic signed [XW-1:0] y_q     [0:CORDIC_ITERS];
  logic signed [ZW-1:0] z_q     [0:CORDIC_ITERS-1];
  logic                 flip_q  [0:CORDIC_ITERS];
  logic                 valid_q [0:CORDIC_ITERS];
  logic                 flip;
  logic signed [XW-1:0] x_fin;
  logic signed [XW-1:0] y_fin;

  // fold the left half plane onto the right one
  assign flip = phase[31] ^ phase[30];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid;
    end
    flip_q[0] <= flip;
    x_q[0]    <= XW'(GAIN_Q30);
    y_q[0]    <= '0;
    z_q[0]    <= ZW'($signed(flip ? phase ^ 32'h8000_0000 : phase));
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;
    assign dx  = y_q[i] >>> i;
    assign dy  = x_q[i] >>> i;
    assign ang = $signed(ZW'(ATAN_TURN[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
      flip_q[i+1] <= flip_q[i];
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
      end
    end

    if (i < CORDIC_ITERS - 1) begin : g_zacc
      always_ff @(posedge clk) begin
        z_q[i+1] <= z_q[i][ZW-1] ? z_q[i] + ang : z_q[i] - ang;
      end
    end
  end

  assign x_fin = flip_q[CORDIC_ITERS] ? -x_q[CORDIC_ITERS] : x_q[CORDIC_ITERS];
  assign y_fin = flip_q[CORDIC_ITERS] ? -y_q[CORDIC_ITERS] : y_q[CORDIC_ITERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_q[CORDIC_ITERS];
    end
    result <= 32'(want_cos ? x_fin : y_fin);
  end

endmodule

// ----- rtl/hvd_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_isqrt
// Exact floor square root, one root bit per stage, most significant first.
// ----------------------------------------------------------------------------
module hvd_isqrt import hvd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [SQ_IN_W-1:0] radicand,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  root
);

  localparam int SQ_W = 63;

  logic [SQ_W-1:0]   rem_q   [0:ROOT_W-2];
  logic [ROOT_W-1:0] root_q  [0:ROOT_W-1];
  logic              valid_q [0:ROOT_W-1];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int K = ROOT_W - 1 - j;
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic              v_in;
    logic [SQ_W-1:0]   trial;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in  = SQ_W'(radicand);
      assign root_in = '0;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign v_in    = valid_q[j-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = (SQ_W'(root_in) << (K + 1)) + (SQ_W'(1) << (2 * K));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[j] <= 1'b0;
      end else begin
        valid_q[j] <= v_in;
      end
      root_q[j] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_q[j] <= take ? rem_in - trial : rem_in;
      end
    end
  end

  assign out_valid = valid_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];

endmodule

// ----- rtl/hvd_atan2.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvd_atan2
// Vectoring-mode CORDIC, one iteration per stage; turn phase of atan2(y, x)
// for nonnegative inputs, negative residue clamped to zero.
// ----------------------------------------------------------------------------
module hvd_atan2 import hvd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROOT_W-1:0] yv,
  input  logic [ROOT_W-1:0] xv,
  output logic              out_valid,
  output logic [ROOT_W-1:0] angle
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_q     [0:CORDIC_ITERS-2];
  logic signed [XW-1:0] y_q     [0:CORDIC_ITERS-2];
  logic signed [ZW-1:0] z_q     [0:CORDIC_ITERS-1];
  logic                 valid_q [0:CORDIC_ITERS-1];

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    logic signed [XW-1:0] x_in;
    logic signed [XW-1:0] y_in;
    logic signed [ZW-1:0] z_in;
    logic                 v_in;
    logic signed [ZW-1:0] ang;

    if (i == 0) begin : g_first
      assign x_in = $signed(XW'(xv));
      assign y_in = $signed(XW'(yv));
      assign z_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign y_in = y_q[i-1];
      assign z_in = z_q[i-1];
      assign v_in = valid_q[i-1];
    end

    assign ang = $signed(ZW'(ATAN_TURN[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= v_in;
      end
      z_q[i] <= y_in[XW-1] ? z_in - ang : z_in + ang;
    end

    if (i < CORDIC_ITERS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (!y_in[XW-1]) begin
          x_q[i] <= x_in + (y_in >>> i);
          y_q[i] <= y_in - (x_in >>> i);
        end else begin
          x_q[i] <= x_in - (y_in >>> i);
          y_q[i] <= y_in + (x_in >>> i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_q[CORDIC_ITERS-1];
    end
    angle <= z_q[CORDIC_ITERS-1][ZW-1] ? '0 : z_q[CORDIC_ITERS-1][ROOT_W-1:0];
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for haversine_distance. Point pairs are sent on the
// command channel with random gaps, the expected distance is worked out by a
// bit-accurate fixed-point predictor, and every done strobe is checked in
// order against the oldest pending distance. The radius register is set to
// several values between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top import hvd_pkg::*; ();

  localparam int LATENCY    = 116;
  localparam int LAT_MAX    = 5898240;
  localparam int LON_MAX    = 11796480;

  // predictor and store of pending distances
  class distance_scoreboard;
    logic [15:0] radius_km;
    logic [25:0] pending_km[$];
    int          mismatches;

    function new();
      radius_km  = 16'(RADIUS_RESET);
      mismatches = 0;
    endfunction

    // floor shift right, also for negatives
    function automatic longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    // round-half-up of deg * 65536 / div, wrapped to a 32 bit turn
    function automatic logic [31:0] turn_phase(longint deg_q16, longint div);
      longint t, q;
      t = deg_q16 * 65536 + div / 2;
      q = t / div;
      if ((t % div) != 0 && t < 0) q--;
      return q[31:0];
    endfunction

    function automatic void rotate(logic [31:0] ph, output longint s, output longint c);
      logic   flip;
      longint x, y, z, dx, dy;
      flip = ph[31] ^ ph[30];
      x = GAIN_Q30;
      y = 0;
      if (flip) ph = ph + 32'h8000_0000;
      z = longint'($signed(ph));
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv; y = yv; z = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
        end
      end
      return z;
    endfunction

    function automatic longint floor_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function automatic logic [25:0] great_circle(longint lat1, longint lon1,
                                                  longint lat2, longint lon2);
      longint s_lat, s_lon, c1, c2, unused, t1, t2, hav, ra, rb, z, c, d;
      rotate(turn_phase(lat2 - lat1, 720), s_lat, unused);
      rotate(turn_phase(lon2 - lon1, 720), s_lon, unused);
      rotate(turn_phase(lat1, 360), unused, c1);
      rotate(turn_phase(lat2, 360), unused, c2);
      t1 = floor_shr(s_lat * s_lat, 30);
      t2 = floor_shr(floor_shr(c1 * c2, 30) * floor_shr(s_lon * s_lon, 30), 30);
      hav = t1 + t2;
      if (hav < 0) hav = 0;               // clamp a into [0, 1]
      if (hav > ONE_Q30) hav = ONE_Q30;
      ra = floor_root(hav << 30);
      rb = floor_root((longint'(ONE_Q30) - hav) << 30);
      z = vector_angle(ra, rb);
      if (z < 0) z = 0;                   // rounding residue below zero
      c = (z * longint'(PI_Q29) + (64'sd1 << 28)) >>> 29;
      d = (longint'(radius_km) * c + (64'sd1 << 21)) >>> 22;
      if (d > DIST_MAX) d = DIST_MAX;     // saturate
      return d[25:0];
    endfunction

    function void note_command(longint lat1, longint lon1, longint lat2, longint lon2);
      pending_km.insert(pending_km.size(), great_circle(lat1, lon1, lat2, lon2));
    endfunction

    function void check_distance(logic [25:0] got);
      logic [25:0] want;
      if (pending_km.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: distance_km=%0d", got);
        return;
      end
      want = pending_km.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("distance_km mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [23:0] first_latitude;
  logic signed [24:0] first_longitude;
  logic signed [23:0] second_latitude;
  logic signed [24:0] second_longitude;
  logic               done;
  logic [25:0]        distance_km;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  distance_scoreboard board;
  bit                 calm;   // no idling in the closing stretch

  haversine_distance i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .first_latitude   (first_latitude),
    .first_longitude  (first_longitude),
    .second_latitude  (second_latitude),
    .second_longitude (second_longitude),
    .done             (done),
    .distance_km      (distance_km),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // results cannot be held off: check every done strobe at the edge
  always @(posedge clk) begin
    if (!rst && done) board.check_distance(distance_km);
  end

  // one command transaction; a random gap burst may come first
  task automatic send_points(longint lat1, longint lon1, longint lat2, longint lon2);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start            <= 1'b1;
    first_latitude   <= lat1[23:0];
    first_longitude  <= lon1[24:0];
    second_latitude  <= lat2[23:0];
    second_longitude <= lon2[24:0];
    do @(posedge clk); while (busy);
    // predict from the field values as the block sees them
    board.note_command(longint'($signed(lat1[23:0])), longint'($signed(lon1[24:0])),
                       longint'($signed(lat2[23:0])), longint'($signed(lon2[24:0])));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending_km.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // radius write while idle
  task automatic set_radius(logic [15:0] km);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= km;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.radius_km = km;
  endtask

  // random coordinate: mostly in range, sometimes anywhere in the field
  function automatic longint rand_coord(int lim, int w);
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 9) == 0)
      return longint'($signed(32'(r << (32 - w)))) >>> (32 - w);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic random_pairs(int n);
    longint la, lo;
    for (int k = 0; k < n; k++) begin
      la = rand_coord(LAT_MAX, 24);
      lo = rand_coord(LON_MAX, 25);
      case ($urandom_range(0, 4))
        0: send_points(la, lo, la, lo);                          // same point
        1: send_points(la, lo, -la, lo + ((lo < 0) ? LON_MAX : -LON_MAX)); // near antipode
        2: send_points(la, lo, la + $urandom_range(0, 4095) - 2048,
                       lo + $urandom_range(0, 4095) - 2048);     // short hop
        default: send_points(la, lo, rand_coord(LAT_MAX, 24), rand_coord(LON_MAX, 25));
      endcase
    end
  endtask

  initial begin
    board            = new();
    calm             = 1'b0;
    rst              = 1'b1;
    start            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    first_latitude   = '0;
    first_longitude  = '0;
    second_latitude  = '0;
    second_longitude = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, poles, antipodes, wrap-around, out-of-range fields
    send_points(0, 0, 0, 0);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(0, 0, 0, LON_MAX);
    send_points(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_points(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
    send_points(2883584, 0, -2883584, LON_MAX);
    send_points(-8388608, -16777216, 8388607, 16777215);
    send_points(8388607, 16777215, -8388608, -16777216);
    send_points(0, 0, 1, 1);
    send_points(-1, -1, 0, 0);
    send_points(0, 0, 0, 11796479);
    send_points(3000000, 5000000, -3000000, -6796480);

    set_radius(16'd0);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    random_pairs(200);
    set_radius(16'hFFFF);                 // saturation at the top
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    send_points(0, 0, 0, LON_MAX);
    random_pairs(300);
    set_radius(16'd1);
    random_pairs(300);
    set_radius(16'(RADIUS_RESET));
    random_pairs(400);
    set_radius(16'($urandom_range(1, 65535)));
    random_pairs(400);
    drain();                               // sender waits for every result
    calm = 1'b1;
    random_pairs(300);
    start <= 1'b0;

    while (board.pending_km.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hvd_pkg.sv
rtl/hvd_phase.sv
rtl/hvd_rotator.sv
rtl/hvd_isqrt.sv
rtl/hvd_atan2.sv
rtl/haversine_distance.sv
tb/sv/tb_top.sv
